### rtl/fnas_pkg.sv
// Package of the four-neighbor average stencil: widths, register indexes,
// queue sizing, the descriptor passed from front to back, and the size clamp.
// Depends on nothing.
`default_nettype none

package fnas_pkg;

   localparam int CELL_W      = 32;
   localparam int POS_W       = 10;
   localparam int DIM_REG_W   = 11;
   localparam int DIM_CLAMP_W = 17;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 4'd1;

   localparam logic [DIM_REG_W-1:0]   DIM_RESET = 11'd64;
   localparam logic [DIM_CLAMP_W-1:0] DIM_MIN   = 17'd3;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
   localparam int FILL_W     = FIFO_CNT_W + 1;

   localparam logic [1:0] OFS_MINUS = 2'd0;
   localparam logic [1:0] OFS_ZERO  = 2'd1;
   localparam logic [1:0] OFS_PLUS  = 2'd2;

   localparam logic signed [CELL_W-1:0] PEAK_MIN = {1'b1, {(CELL_W-1){1'b0}}};

   typedef struct packed {
      logic [POS_W-1:0]         row;
      logic [POS_W-1:0]         col;
      logic signed [CELL_W-1:0] value;
      logic signed [CELL_W-1:0] peak;
      logic                     top;
      logic                     bottom;
      logic                     left;
      logic                     right;
   } desc_type;

   function automatic logic [DIM_CLAMP_W-1:0] clamp_dim(logic [DIM_REG_W-1:0] v,
                                                        int unsigned maxv);
      logic [DIM_CLAMP_W-1:0] w;
      logic [DIM_CLAMP_W-1:0] m;
      w = DIM_CLAMP_W'(v);
      m = DIM_CLAMP_W'(maxv);
      if (w < DIM_MIN) begin
         w = DIM_MIN;
      end else if (w > m) begin
         w = m;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

### rtl/four_neighbor_average_stencil_top.sv
// Top level of the four-neighbor average stencil: front, descriptor queue and
// back end. Uses fnas_pkg, fnas_front, fnas_queue and fnas_back.
//
//   channel   direction   handshake             payload
//   req_      in          req_push / req_full   req_cell_value
//   rsp_      out         rsp_pop / rsp_empty   row, col, value, peak, done
//   csr_      in          csr_valid / csr_ready csr_index, csr_wdata
//
// A cell enters in every cycle while the queue has room, and a word leaves in every
// cycle while rsp_pop is high. A whole grid gives one word per cell, so the intake
// averages close to one cell per cycle; a burst of up to nine words at an edge
// stalls it.
// Reset empties the pipeline, the queue and the output word and sets both grid
// sizes to 64; the line memories are not cleared.
// req_full rises when the queued descriptors plus the cells in the two pipeline
// stages reach the queue depth; a low rsp_pop holds the output word and backs up
// the queue.
`default_nettype none

module four_neighbor_average_stencil_top #(
   parameter int MAX_ROWS = 1024,
   parameter int MAX_COLS = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [fnas_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fnas_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic signed [fnas_pkg::CELL_W-1:0]  req_cell_value,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [fnas_pkg::POS_W-1:0]               rsp_out_row,
   output logic [fnas_pkg::POS_W-1:0]               rsp_out_col,
   output logic signed [fnas_pkg::CELL_W-1:0]       rsp_out_value,
   output logic signed [fnas_pkg::CELL_W-1:0]       rsp_peak_so_far,
   output logic                                     rsp_grid_done
);

   logic                            q_push;
   fnas_pkg::desc_type              q_desc;
   logic                            q_pop;
   fnas_pkg::desc_type              q_head;
   logic                            q_head_valid;
   logic [fnas_pkg::FIFO_CNT_W-1:0] q_count;

   assign csr_ready = 1'b1;

   fnas_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cell_value (req_cell_value),
      .q_count        (q_count),
      .q_push         (q_push),
      .q_desc         (q_desc)
   );

   fnas_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (q_desc),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_head_valid),
      .count      (q_count)
   );

   fnas_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .head_valid      (q_head_valid),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_value   (rsp_out_value),
      .rsp_peak_so_far (rsp_peak_so_far),
      .rsp_grid_done   (rsp_grid_done)
   );

endmodule

`default_nettype wire

### rtl/fnas_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// A read of the address being written returns the old contents. No dependencies.
`default_nettype none

module fnas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/fnas_front.sv
// Front of the stencil: grid size registers, raster counters, two line memories,
// the four-neighbor average and the running peak. Uses fnas_pkg and fnas_ram.
`default_nettype none

module fnas_front #(
   parameter int MAX_ROWS = 1024,
   parameter int MAX_COLS = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [fnas_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fnas_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic signed [fnas_pkg::CELL_W-1:0]  req_cell_value,
   input  wire logic [fnas_pkg::FIFO_CNT_W-1:0]     q_count,
   output logic                                     q_push,
   output fnas_pkg::desc_type                       q_desc
);

   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int SW = fnas_pkg::CELL_W + 2;

   localparam logic [RW-1:0] ROWS_LAST_RESET =
      RW'(fnas_pkg::clamp_dim(fnas_pkg::DIM_RESET, MAX_ROWS) - 17'd1);
   localparam logic [CW-1:0] COLS_LAST_RESET =
      CW'(fnas_pkg::clamp_dim(fnas_pkg::DIM_RESET, MAX_COLS) - 17'd1);

   typedef struct packed {
      logic                               first;
      logic                               interior;
      logic                               top;
      logic                               bottom;
      logic                               left;
      logic                               right;
      logic [fnas_pkg::POS_W-1:0]         row;
      logic [fnas_pkg::POS_W-1:0]         col;
      logic signed [fnas_pkg::CELL_W-1:0] value;
   } stage_type;

   logic [RW-1:0] lastr_ff, lastr_in;
   logic [CW-1:0] lastc_ff, lastc_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;

   logic [fnas_pkg::CELL_W-1:0] cen_ff, cen_in;
   logic [fnas_pkg::CELL_W-1:0] west_ff, west_in;

   logic      s1_vld_ff, s1_vld_in;
   stage_type s1_ff, s1_in;
   logic      s2_vld_ff, s2_vld_in;
   stage_type s2_ff, s2_in;

   logic signed [fnas_pkg::CELL_W-1:0] peak_ff, peak_in;
   logic signed [fnas_pkg::CELL_W-1:0] peak_base;

   logic                        accept;
   logic                        cfg_rows;
   logic                        cfg_cols;
   logic                        col_wrap;
   logic                        row_wrap;
   logic [RW-1:0]               row_m1;
   logic [RW-1:0]               rows_last;
   logic [CW-1:0]               cols_last;
   logic [CW-1:0]               mid_raddr;
   logic [fnas_pkg::CELL_W-1:0] up_rdata;
   logic [fnas_pkg::CELL_W-1:0] mid_rdata;
   logic signed [SW-1:0]        sum;
   logic [fnas_pkg::FILL_W-1:0] fill;

   assign fill = {1'b0, q_count} + fnas_pkg::FILL_W'(s1_vld_ff)
                 + fnas_pkg::FILL_W'(s2_vld_ff);
   assign req_full = fill >= fnas_pkg::FILL_W'(fnas_pkg::FIFO_DEPTH);
   assign accept   = req_push && !req_full;

   assign cfg_rows  = csr_valid && (csr_index == fnas_pkg::CSR_GRID_ROWS);
   assign cfg_cols  = csr_valid && (csr_index == fnas_pkg::CSR_GRID_COLS);
   assign rows_last = RW'(fnas_pkg::clamp_dim(csr_wdata[fnas_pkg::DIM_REG_W-1:0],
                                              MAX_ROWS) - 17'd1);
   assign cols_last = CW'(fnas_pkg::clamp_dim(csr_wdata[fnas_pkg::DIM_REG_W-1:0],
                                              MAX_COLS) - 17'd1);

   assign col_wrap  = col_ff == lastc_ff;
   assign row_wrap  = row_ff == lastr_ff;
   assign row_m1    = row_ff - RW'(1);
   assign mid_raddr = col_wrap ? '0 : col_ff + CW'(1);

   // Upper holds the row two back, middle the row one back. The middle read runs
   // one column ahead, so its data serves as the east neighbor now and as the
   // center of the next cell.
   fnas_ram #(
      .WIDTH (fnas_pkg::CELL_W),
      .DEPTH (MAX_COLS)
   ) u_upper (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (mid_rdata),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (up_rdata)
   );

   fnas_ram #(
      .WIDTH (fnas_pkg::CELL_W),
      .DEPTH (MAX_COLS)
   ) u_middle (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_cell_value),
      .rd_en   (accept),
      .rd_addr (mid_raddr),
      .rd_data (mid_rdata)
   );

   assign sum = {{2{up_rdata[fnas_pkg::CELL_W-1]}}, up_rdata}
              + {{2{mid_rdata[fnas_pkg::CELL_W-1]}}, mid_rdata}
              + {{2{west_ff[fnas_pkg::CELL_W-1]}}, west_ff}
              + {{2{s1_ff.value[fnas_pkg::CELL_W-1]}}, s1_ff.value};

   assign peak_base = s2_ff.first ? fnas_pkg::PEAK_MIN : peak_ff;

   always_comb begin
      lastr_in = cfg_rows ? rows_last : lastr_ff;
      lastc_in = cfg_cols ? cols_last : lastc_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      if (cfg_rows || cfg_cols) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end

      cen_in  = accept ? mid_rdata : cen_ff;
      west_in = accept ? cen_ff : west_ff;

      s1_vld_in      = accept;
      s1_in          = s1_ff;
      if (accept) begin
         s1_in.first    = (row_ff == '0) && (col_ff == '0);
         s1_in.interior = (row_ff > RW'(1)) && (col_ff != '0) && !col_wrap;
         s1_in.top      = row_ff == RW'(2);
         s1_in.bottom   = row_wrap;
         s1_in.left     = col_ff == CW'(1);
         s1_in.right    = col_ff == lastc_ff - CW'(1);
         s1_in.row      = fnas_pkg::POS_W'(row_m1);
         s1_in.col      = fnas_pkg::POS_W'(col_ff);
         s1_in.value    = req_cell_value;
      end

      s2_vld_in = s1_vld_ff;
      s2_in     = s2_ff;
      if (s1_vld_ff) begin
         s2_in       = s1_ff;
         s2_in.value = sum[SW-1:2];
      end

      peak_in = peak_ff;
      if (s2_vld_ff) begin
         peak_in = peak_base;
         if (s2_ff.interior && (s2_ff.value > peak_base)) begin
            peak_in = s2_ff.value;
         end
      end
   end

   assign q_push        = s2_vld_ff && s2_ff.interior;
   assign q_desc.row    = s2_ff.row;
   assign q_desc.col    = s2_ff.col;
   assign q_desc.value  = s2_ff.value;
   assign q_desc.peak   = peak_in;
   assign q_desc.top    = s2_ff.top;
   assign q_desc.bottom = s2_ff.bottom;
   assign q_desc.left   = s2_ff.left;
   assign q_desc.right  = s2_ff.right;

   always_ff @(posedge clock) begin
      if (reset) begin
         lastr_ff  <= ROWS_LAST_RESET;
         lastc_ff  <= COLS_LAST_RESET;
         row_ff    <= '0;
         col_ff    <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         peak_ff   <= fnas_pkg::PEAK_MIN;
      end else begin
         lastr_ff  <= lastr_in;
         lastc_ff  <= lastc_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         peak_ff   <= peak_in;
      end
      cen_ff  <= cen_in;
      west_ff <= west_in;
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
   end

endmodule

`default_nettype wire

### rtl/fnas_queue.sv
// Short descriptor queue between the stencil front and the burst back end.
// Uses fnas_pkg.
`default_nettype none

module fnas_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire fnas_pkg::desc_type            push_desc,
   input  wire logic                          pop,
   output fnas_pkg::desc_type                 head,
   output logic                               head_valid,
   output logic [fnas_pkg::FIFO_CNT_W-1:0]    count
);

   fnas_pkg::desc_type slot_ff [fnas_pkg::FIFO_DEPTH];

   logic [fnas_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fnas_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fnas_pkg::FIFO_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + fnas_pkg::FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + fnas_pkg::FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + fnas_pkg::FIFO_CNT_W'(push) - fnas_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign head       = slot_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;
   assign count      = count_ff;

endmodule

`default_nettype wire

### rtl/fnas_back.sv
// Back end of the stencil: expands each descriptor into its burst of one to nine
// words and holds the output word. Uses fnas_pkg.
`default_nettype none

module fnas_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire fnas_pkg::desc_type                 head,
   input  wire logic                               head_valid,
   output logic                                    q_pop,
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output logic [fnas_pkg::POS_W-1:0]              rsp_out_row,
   output logic [fnas_pkg::POS_W-1:0]              rsp_out_col,
   output logic signed [fnas_pkg::CELL_W-1:0]      rsp_out_value,
   output logic signed [fnas_pkg::CELL_W-1:0]      rsp_peak_so_far,
   output logic                                    rsp_grid_done
);

   logic       started_ff, started_in;
   logic [1:0] dr_ff, dr_in;
   logic [1:0] dc_ff, dc_in;

   logic                               vld_ff, vld_in;
   logic [fnas_pkg::POS_W-1:0]         row_ff, row_in;
   logic [fnas_pkg::POS_W-1:0]         col_ff, col_in;
   logic signed [fnas_pkg::CELL_W-1:0] value_ff, value_in;
   logic signed [fnas_pkg::CELL_W-1:0] peak_ff, peak_in;
   logic                               done_ff, done_in;

   logic [1:0] first_dr, last_dr, first_dc, last_dc, cur_dr, cur_dc;
   logic       emit, last_dc_hit, burst_end;

   assign first_dr    = head.top ? fnas_pkg::OFS_MINUS : fnas_pkg::OFS_ZERO;
   assign last_dr     = head.bottom ? fnas_pkg::OFS_PLUS : fnas_pkg::OFS_ZERO;
   assign first_dc    = head.left ? fnas_pkg::OFS_MINUS : fnas_pkg::OFS_ZERO;
   assign last_dc     = head.right ? fnas_pkg::OFS_PLUS : fnas_pkg::OFS_ZERO;
   assign cur_dr      = started_ff ? dr_ff : first_dr;
   assign cur_dc      = started_ff ? dc_ff : first_dc;
   assign last_dc_hit = cur_dc == last_dc;
   assign burst_end   = last_dc_hit && (cur_dr == last_dr);
   assign emit        = head_valid && (!vld_ff || rsp_pop);
   assign q_pop       = emit && burst_end;

   always_comb begin
      started_in = started_ff;
      dr_in      = dr_ff;
      dc_in      = dc_ff;
      vld_in     = vld_ff && !rsp_pop;
      row_in     = row_ff;
      col_in     = col_ff;
      value_in   = value_ff;
      peak_in    = peak_ff;
      done_in    = done_ff;
      if (emit) begin
         started_in = !burst_end;
         if (last_dc_hit) begin
            dr_in = cur_dr + 2'd1;
            dc_in = first_dc;
         end else begin
            dr_in = cur_dr;
            dc_in = cur_dc + 2'd1;
         end
         vld_in   = 1'b1;
         row_in   = head.row + {{(fnas_pkg::POS_W-2){1'b0}}, cur_dr}
                    - fnas_pkg::POS_W'(1);
         col_in   = head.col + {{(fnas_pkg::POS_W-2){1'b0}}, cur_dc}
                    - fnas_pkg::POS_W'(1);
         value_in = head.value;
         peak_in  = head.peak;
         done_in  = head.bottom && head.right && burst_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         vld_ff     <= 1'b0;
      end else begin
         started_ff <= started_in;
         vld_ff     <= vld_in;
      end
      dr_ff    <= dr_in;
      dc_ff    <= dc_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      value_ff <= value_in;
      peak_ff  <= peak_in;
      done_ff  <= done_in;
   end

   assign rsp_empty       = !vld_ff;
   assign rsp_out_row     = row_ff;
   assign rsp_out_col     = col_ff;
   assign rsp_out_value   = value_ff;
   assign rsp_peak_so_far = peak_ff;
   assign rsp_grid_done   = done_ff;

endmodule

`default_nettype wire

### rtl/fnas_checker.sv
// Port-level checks of the four-neighbor average stencil and the bind that
// attaches them to four_neighbor_average_stencil_top. No package dependencies.
`default_nettype none

module fnas_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_full,
   input wire logic               rsp_empty,
   input wire logic               rsp_pop,
   input wire logic [9:0]         rsp_out_row,
   input wire logic [9:0]         rsp_out_col,
   input wire logic signed [31:0] rsp_out_value,
   input wire logic signed [31:0] rsp_peak_so_far,
   input wire logic               rsp_grid_done
);

   // A word that is not taken stays on the ports unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_row)
         && $stable(rsp_out_col) && $stable(rsp_out_value)
         && $stable(rsp_peak_so_far) && $stable(rsp_grid_done)))
      else $error("result word changed while stalled");

   // The running peak is at least the value carried by the word on the ports.
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_peak_so_far >= rsp_out_value))
      else $error("peak below the word's value");

   // Reset leaves no word pending and the input open.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("state left over after reset");

endmodule

bind four_neighbor_average_stencil_top fnas_checker u_checker (.*);

`default_nettype wire
